>>> src/tsjq_pkg.sv
package tsjq_pkg;

   // Default number of entries the queue can hold.
   localparam int TSJQ_DEPTH = 16;

   // Request operation codes.
   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_FIND   = 2'd2;
   localparam logic [1:0] FUNC_LIST   = 2'd3;

   // Response status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;
   localparam logic [1:0] STATUS_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [21:0] pid;
      logic [31:0] run_time;
      logic [15:0] command_tag;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [21:0] out_pid;
      logic [31:0] out_run_time;
      logic [15:0] out_command_tag;
      logic        is_last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] run_time;
      logic [21:0] pid;
      logic [15:0] command_tag;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_WALK,
      ST_INS_PUT,
      ST_REM_OUT,
      ST_FIND_WALK,
      ST_LIST_OUT,
      ST_RESP
   } state_type;

endpackage

>>> src/time_sorted_job_queue.sv
// Shortest-time-first job queue. Up to DEPTH entries (run time, process id, command tag)
// are kept in one single-port-read, single-port-write memory as a circular list in
// ascending order of run time; entries with equal run times leave in arrival order.
// Requests are taken one at a time: a new request transfer is taken only when the
// previous one has finished its walk, although its last response may still be waiting
// in the output register. The memory returns one entry per cycle. An insert walks back
// from the last entry, moving up each entry with a larger run time to make room, then
// writes the new entry into the freed slot; remove-head returns the head entry; find
// examines entries from the head until a process id matches or none are left; list
// returns every entry from the head, each waiting for the response side to take the
// previous one. A full insert, a remove or list on an empty queue and a find on an empty
// queue go straight to the response. Any cycle that hands a response to the output
// register also waits while that register still holds a response the receiver has not
// taken. Removing the head only advances the head pointer, so it never moves the other
// entries. The response carries is_last on the final transfer of each request; only a
// list on a non-empty queue gives more than one response.
module time_sorted_job_queue #(
   parameter int DEPTH = tsjq_pkg::TSJQ_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tsjq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tsjq_pkg::rsp_type rsp_data
);
   import tsjq_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // memory address width
   localparam int CW = $clog2(DEPTH + 1);                // entry count width
   localparam int SW = CW + 1;                           // head plus count

   // Pointers wrap at DEPTH, which need not be a power of two.
   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
      ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
      ptr_dec = (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
   endfunction

   state_type       state_ff, state_in;
   logic [AW-1:0]   head_ff, head_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   rem_ff, rem_in;
   logic [AW-1:0]   rdptr_ff, rdptr_in;
   logic [AW-1:0]   wrptr_ff, wrptr_in;
   req_type         req_ff, req_in;
   rsp_type         resp_ff, resp_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   entry_type       mem_ram [DEPTH];
   entry_type       rd_data_ff;
   logic            mem_we;
   logic [AW-1:0]   mem_waddr;
   entry_type       mem_wdata;
   logic            mem_re;
   logic [AW-1:0]   mem_raddr;

   logic            req_accept;
   logic            out_free;
   logic            rem_last;
   logic            count_zero;
   logic            count_full;
   logic [SW-1:0]   tail_sum;
   logic [SW-1:0]   tail_wrap;
   logic [AW-1:0]   tail_ptr;
   entry_type       new_entry;
   logic            walk_moves;
   logic            find_match;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign rem_last   = (rem_ff == CW'(1));
   assign count_zero = (count_ff == '0);
   assign count_full = (count_ff == CW'(DEPTH));

   // First free slot after the last entry.
   assign tail_sum  = SW'(head_ff) + SW'(count_ff);
   assign tail_wrap = (tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum;
   assign tail_ptr  = tail_wrap[AW-1:0];

   assign new_entry  = '{run_time: req_ff.run_time, pid: req_ff.pid,
                         command_tag: req_ff.command_tag};
   // An entry with a larger run time moves up one place to make room.
   assign walk_moves = (rd_data_ff.run_time > req_ff.run_time);
   assign find_match = (rd_data_ff.pid == req_ff.pid);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_data.func)
                  FUNC_INSERT: begin
                     if (count_full) begin
                        state_in = ST_RESP;
                     end else if (count_zero) begin
                        state_in = ST_INS_PUT;
                     end else begin
                        state_in = ST_INS_WALK;
                     end
                  end
                  FUNC_REMOVE: state_in = count_zero ? ST_RESP : ST_REM_OUT;
                  FUNC_FIND:   state_in = count_zero ? ST_RESP : ST_FIND_WALK;
                  FUNC_LIST:   state_in = count_zero ? ST_RESP : ST_LIST_OUT;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_INS_WALK: begin
            if (!walk_moves) begin
               state_in = ST_RESP;
            end else if (rem_last) begin
               state_in = ST_INS_PUT;
            end
         end
         ST_INS_PUT: state_in = ST_RESP;
         ST_REM_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_FIND_WALK: begin
            if (find_match || rem_last) begin
               state_in = ST_RESP;
            end
         end
         ST_LIST_OUT: begin
            if (out_free && rem_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      rem_in       = rem_ff;
      rdptr_in     = rdptr_ff;
      wrptr_in     = wrptr_ff;
      req_in       = req_ff;
      resp_in      = resp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = wrptr_ff;
      mem_wdata    = new_entry;
      mem_re       = 1'b0;
      mem_raddr    = rdptr_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               req_in  = req_data;
               rem_in  = count_ff;
               resp_in = '{status: STATUS_OK, out_pid: '0, out_run_time: '0,
                           out_command_tag: '0, is_last: 1'b1};
               case (req_data.func)
                  FUNC_INSERT: begin
                     if (count_full) begin
                        resp_in.status = STATUS_FULL;
                     end else begin
                        // An accepted insert echoes the new entry.
                        resp_in.out_pid         = req_data.pid;
                        resp_in.out_run_time    = req_data.run_time;
                        resp_in.out_command_tag = req_data.command_tag;
                        wrptr_in  = tail_ptr;
                        rdptr_in  = ptr_dec(tail_ptr);
                        mem_re    = !count_zero;
                        mem_raddr = ptr_dec(tail_ptr);
                     end
                  end
                  FUNC_REMOVE, FUNC_LIST: begin
                     resp_in.status = STATUS_EMPTY;
                     rdptr_in  = head_ff;
                     mem_re    = !count_zero;
                     mem_raddr = head_ff;
                  end
                  FUNC_FIND: begin
                     resp_in.status = STATUS_NOTFOUND;
                     rdptr_in  = head_ff;
                     mem_re    = !count_zero;
                     mem_raddr = head_ff;
                  end
                  default: begin
                     resp_in.status = STATUS_OK;
                  end
               endcase
            end
         end
         ST_INS_WALK: begin
            mem_we = 1'b1;
            if (walk_moves) begin
               mem_wdata = rd_data_ff;
               wrptr_in  = rdptr_ff;
               if (!rem_last) begin
                  rdptr_in  = ptr_dec(rdptr_ff);
                  rem_in    = rem_ff - 1'b1;
                  mem_re    = 1'b1;
                  mem_raddr = ptr_dec(rdptr_ff);
               end
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         ST_INS_PUT: begin
            mem_we   = 1'b1;
            count_in = count_ff + 1'b1;
         end
         ST_REM_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{status: STATUS_OK, out_pid: rd_data_ff.pid,
                                out_run_time: rd_data_ff.run_time,
                                out_command_tag: rd_data_ff.command_tag, is_last: 1'b1};
               head_in  = ptr_inc(head_ff);
               count_in = count_ff - 1'b1;
            end
         end
         ST_FIND_WALK: begin
            if (find_match) begin
               resp_in = '{status: STATUS_OK, out_pid: rd_data_ff.pid,
                           out_run_time: rd_data_ff.run_time,
                           out_command_tag: rd_data_ff.command_tag, is_last: 1'b1};
            end else if (!rem_last) begin
               rdptr_in  = ptr_inc(rdptr_ff);
               rem_in    = rem_ff - 1'b1;
               mem_re    = 1'b1;
               mem_raddr = ptr_inc(rdptr_ff);
            end
         end
         ST_LIST_OUT: begin
            // The read data register holds while the response side stalls.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{status: STATUS_OK, out_pid: rd_data_ff.pid,
                                out_run_time: rd_data_ff.run_time,
                                out_command_tag: rd_data_ff.command_tag,
                                is_last: rem_last};
               if (!rem_last) begin
                  rdptr_in  = ptr_inc(rdptr_ff);
                  rem_in    = rem_ff - 1'b1;
                  mem_re    = 1'b1;
                  mem_raddr = ptr_inc(rdptr_ff);
               end
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = resp_ff;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_ready;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rdptr_ff    <= rdptr_in;
      wrptr_ff    <= wrptr_in;
      req_ff      <= req_in;
      resp_ff     <= resp_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Entry memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ram[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem_ram[mem_raddr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count beyond capacity");

   a_walk_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INS_WALK && mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("insert walk reads the slot it writes");

   a_walk_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INS_WALK || state_ff == ST_FIND_WALK || state_ff == ST_LIST_OUT)
      |-> (rem_ff != '0))
      else $error("walk running with no entries left");

   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REM_OUT && out_free) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("remove did not drop one entry");

   a_partial_list: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.is_last) |-> (state_ff == ST_LIST_OUT))
      else $error("non-final response outside a list");
`endif

endmodule
